@@ rtl/hsbhm_pkg.sv @@
// ----------------------------------------------------------------------------
// hsbhm_pkg: shared types and codes for the HSB histogram block
// Command codes, channel codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package hsbhm_pkg;

  // command codes carried in the op field
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // query channel codes
  localparam logic [1:0] CH_HUE    = 2'd0;
  localparam logic [1:0] CH_SAT    = 2'd1;
  localparam logic [1:0] CH_BRIGHT = 2'd2;

  // Q16 one and the step count of the shared divide/multiply unit
  localparam logic [17:0] Q16_ONE     = 18'd65536;
  localparam int          FRAC_BITS   = 17;
  localparam logic [4:0]  ARITH_STEPS = 5'd17;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_run;
    logic add_rd;
    logic add_wr;
    logic sum_start;
    logic sum_run;
    logic arith_start;
    logic arith_run;
    logic pct_start;
    logic pct_run;
    logic out_load;
  } hsbhm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic sum_done;
    logic arith_done;
    logic pct_done;
    logic out_free;
  } hsbhm_stat_t;

endpackage

@@ rtl/hsbhm_datapath.sv @@
// ----------------------------------------------------------------------------
// hsbhm_datapath: count memories, scan pipelines and arithmetic
// Three banked count memories, the sum and percentile scans, a shared
// restoring divider / shift-add multiplier, and the result register.
// ----------------------------------------------------------------------------
module hsbhm_datapath import hsbhm_pkg::*; #(
  parameter int BIN_MAX     = 255,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  hsbhm_cmd_t  cmd,
  output hsbhm_stat_t stat,
  input  logic [39:0] in_data,
  input  logic        cfg_valid,
  input  logic [16:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_data
);

  localparam int BIN_BITS = $clog2(BIN_MAX + 1);
  localparam int TW       = COUNT_WIDTH + BIN_BITS;
  localparam int WW       = COUNT_WIDTH + 2 * BIN_BITS;
  localparam int MW       = TW + FRAC_BITS;
  localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(BIN_MAX);

  // configuration register
  logic [16:0] pfrac;
  always_ff @(posedge clk) begin
    if (rst) begin
      pfrac <= 17'd32768;
    end else if (cfg_valid) begin
      pfrac <= cfg_data;
    end
  end

  // captured command word
  logic [1:0]          ch;
  logic [2:0]          pix_ok;
  logic [BIN_BITS-1:0] pix_addr [3];
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch <= in_data[33:32];
      for (int b = 0; b < 3; b++) begin
        logic [9:0] v;
        v = in_data[2+10*b +: 10];
        pix_ok[b]   <= !v[9] && ({1'b0, v} <= 11'(BIN_MAX));
        pix_addr[b] <= BIN_BITS'(v);
      end
    end
  end

  // clear sweep counter
  logic [BIN_BITS-1:0] ccnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt <= '0;
    end else if (cmd.clr_run) begin
      ccnt <= (ccnt == LAST_BIN) ? '0 : ccnt + 1'b1;
    end
  end

  // scan counters (declared here for the address mux)
  logic [BIN_BITS-1:0] scnt, pcnt;

  // count memories, one per channel
  logic [COUNT_WIDTH-1:0] rdata [3];
  for (genvar b = 0; b < 3; b++) begin : g_bank
    logic [COUNT_WIDTH-1:0] mem [BIN_MAX+1];
    logic [BIN_BITS-1:0]    raddr, waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic                   we;

    always_comb begin
      raddr = cmd.pct_run ? pcnt : (cmd.sum_run ? scnt : pix_addr[b]);
      if (cmd.clr_run) begin
        we    = 1'b1;
        waddr = ccnt;
        wdata = '0;
      end else begin
        we    = cmd.add_wr && pix_ok[b] && (rdata[b] != '1);
        waddr = pix_addr[b];
        wdata = rdata[b] + 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata[b] <= mem[raddr];
    end
  end

  // read data of the queried channel
  logic [COUNT_WIDTH-1:0] sel;
  always_comb begin
    unique case (ch)
      CH_HUE:    sel = rdata[0];
      CH_SAT:    sel = rdata[1];
      CH_BRIGHT: sel = rdata[2];
      default:   sel = '0;
    endcase
  end

  // sum scan: issue, read, multiply, accumulate
  logic                siss, v1, v2;
  logic [BIN_BITS-1:0] i1;
  logic [WW-1:0]       prod, weighted;
  logic [TW-1:0]       total;
  always_ff @(posedge clk) begin
    if (rst) begin
      siss <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else if (cmd.sum_start) begin
      siss <= 1'b1;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      v1 <= siss && cmd.sum_run;
      v2 <= v1;
      if (siss && cmd.sum_run && scnt == LAST_BIN) begin
        siss <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      scnt     <= '0;
      total    <= '0;
      weighted <= '0;
    end else begin
      if (siss && cmd.sum_run) begin
        i1   <= scnt;
        scnt <= scnt + 1'b1;
      end
      if (v1) begin
        total <= total + TW'(sel);
        prod  <= WW'(sel) * WW'(i1);
      end
      if (v2) begin
        weighted <= weighted + prod;
      end
    end
  end

  // shared arithmetic: mean by restoring division, target by shift-add
  logic [WW-1:0]       rem, dv;
  logic [BIN_BITS-1:0] q;
  logic [MW-1:0]       acc, mc;
  logic [16:0]         mb;
  logic [4:0]          astep;
  logic [17:0]         pclip;
  logic [TW-1:0]       target;

  assign pclip  = ({1'b0, pfrac} > Q16_ONE) ? Q16_ONE : {1'b0, pfrac};
  assign target = acc[TW+FRAC_BITS-2:FRAC_BITS-1];

  always_ff @(posedge clk) begin
    if (cmd.arith_start) begin
      rem   <= weighted;
      dv    <= WW'(total) << (BIN_BITS - 1);
      q     <= '0;
      acc   <= '0;
      mc    <= MW'(total);
      mb    <= 17'(Q16_ONE - pclip);
      astep <= '0;
    end else if (cmd.arith_run) begin
      if (astep < 5'(BIN_BITS)) begin
        if (rem >= dv) begin
          rem <= rem - dv;
          q   <= {q[BIN_BITS-2:0], 1'b1};
        end else begin
          q   <= {q[BIN_BITS-2:0], 1'b0};
        end
        dv <= dv >> 1;
      end
      if (mb[0]) begin
        acc <= acc + mc;
      end
      mc    <= mc << 1;
      mb    <= mb >> 1;
      astep <= astep + 1'b1;
    end
  end

  // percentile scan, top bin down
  logic                piss, pv, found;
  logic [BIN_BITS-1:0] pi, pbin;
  logic [TW-1:0]       run, run_sum;
  assign run_sum = run + TW'(sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      piss  <= 1'b0;
      pv    <= 1'b0;
      found <= 1'b0;
    end else if (cmd.pct_start) begin
      piss  <= 1'b1;
      pv    <= 1'b0;
      found <= 1'b0;
    end else begin
      pv <= piss && cmd.pct_run && !found;
      if (cmd.pct_run && (pcnt == '0 || found)) begin
        piss <= 1'b0;
      end
      if (pv && !found && run_sum >= target) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pct_start) begin
      pcnt <= LAST_BIN;
      run  <= '0;
      pbin <= '0;
    end else begin
      if (piss && cmd.pct_run) begin
        pi   <= pcnt;
        pcnt <= pcnt - 1'b1;
      end
      if (pv && !found) begin
        run <= run_sum;
        if (run_sum >= target) begin
          pbin <= pi;
        end
      end
    end
  end

  // result register
  logic [63:0] total64;
  logic [15:0] mean16, pct16;
  assign total64 = 64'(total);
  assign mean16  = (total == '0) ? 16'd0 : 16'(q);
  assign pct16   = 16'(pbin);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data[7:0]   <= mean16[7:0];
      out_data[15:8]  <= pct16[7:0];
      out_data[47:16] <= (total64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total64[31:0];
    end
  end

  // status
  assign stat.clr_last   = (ccnt == LAST_BIN);
  assign stat.sum_done   = !siss && !v1 && !v2;
  assign stat.arith_done = (astep == ARITH_STEPS);
  assign stat.pct_done   = found || (!piss && !pv);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

@@ rtl/hsbhm_ctrl.sv @@
// ----------------------------------------------------------------------------
// hsbhm_ctrl: command sequencer
// Decodes each accepted word and steps the datapath through clear, add and
// query phases.
// ----------------------------------------------------------------------------
module hsbhm_ctrl import hsbhm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_ch,
  input  hsbhm_stat_t stat,
  output hsbhm_cmd_t  cmd
);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ADD_RD = 3'd2;
  localparam logic [2:0] S_ADD_WR = 3'd3;
  localparam logic [2:0] S_SUM    = 3'd4;
  localparam logic [2:0] S_ARITH  = 3'd5;
  localparam logic [2:0] S_PCT    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state, state_next;
  logic       take;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.capture     = take;
    cmd.clr_run     = (state == S_CLR);
    cmd.add_rd      = (state == S_ADD_RD);
    cmd.add_wr      = (state == S_ADD_WR);
    cmd.sum_run     = (state == S_SUM);
    cmd.arith_run   = (state == S_ARITH) && !stat.arith_done;
    cmd.pct_run     = (state == S_PCT);
    unique case (state)
      S_CLR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          if (in_op == OP_ADD) begin
            state_next = S_ADD_RD;
          end else if (in_op == OP_CLEAR) begin
            state_next = S_CLR;
          end else if (in_op == OP_QUERY &&
                       (in_ch == CH_HUE || in_ch == CH_SAT || in_ch == CH_BRIGHT)) begin
            state_next    = S_SUM;
            cmd.sum_start = 1'b1;
          end
        end
      end
      S_ADD_RD: state_next = S_ADD_WR;
      S_ADD_WR: state_next = S_IDLE;
      S_SUM: begin
        if (stat.sum_done) begin
          state_next      = S_ARITH;
          cmd.arith_start = 1'b1;
        end
      end
      S_ARITH: begin
        if (stat.arith_done) begin
          state_next    = S_PCT;
          cmd.pct_start = 1'b1;
        end
      end
      S_PCT: begin
        if (stat.pct_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_next   = S_IDLE;
          cmd.out_load = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // checks
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free) else $error("result loaded over a waiting word");
  a_add_seq: assert property (@(posedge clk) disable iff (rst)
    (take && in_op == OP_ADD) |=> state == S_ADD_RD) else $error("add not started");
  a_arith_after_sum: assert property (@(posedge clk) disable iff (rst)
    cmd.arith_start |-> stat.sum_done) else $error("arith started before sums done");
  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_run, cmd.add_wr, cmd.sum_run, cmd.pct_run}))
    else $error("overlapping memory phases");

endmodule

@@ rtl/hsb_histogram_mean_percentile.sv @@
// ----------------------------------------------------------------------------
// hsb_histogram_mean_percentile: HSB histograms with mean and percentile
// Top level joining the command sequencer and the histogram datapath.
// ----------------------------------------------------------------------------
// Each input word is a command. An add reads, then writes back, each count
// memory. A clear sweeps all BIN_MAX+1 bins, one a cycle, and the same sweep
// runs once after reset before the first word is taken. In a query, one pass
// over the bins builds the total and the weighted sum, a 17-step shared unit
// forms the mean and the percentile target, and a second top-down pass finds
// the percentile bin. The result waits in an output register; adds and
// clears go on while it waits, a further query completes only once
// it is taken.
module hsb_histogram_mean_percentile import hsbhm_pkg::*; #(
  parameter int BIN_MAX     = 255,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // hue_value[9:0], sat_value[19:10], bright_value[29:20], zero[31:30]
  input  logic [31:0] s_tdata,
  // op[1:0], channel_select[3:2]
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // mean_bin[7:0], percentile_bin[15:8], pixel_total[47:16]
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  hsbhm_cmd_t  cmd;
  hsbhm_stat_t stat;

  assign cfg_ready = 1'b1;

  hsbhm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser[1:0]),
    .in_ch    (s_tuser[3:2]),
    .stat     (stat),
    .cmd      (cmd)
  );

  hsbhm_datapath #(
    .BIN_MAX     (BIN_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   ({6'b0, s_tuser[3:2], s_tdata[29:0], s_tuser[1:0]}),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
